/* sv/assert_macros.svh */
// Assertion macros shared by the culling RTL, clocked on clk_i and reset by rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, off while reset is asserted.
`define CTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Implication check: when ante holds, cons must hold at the same edge.
`define CTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* sv/ctc_pkg.sv */
// Shared constants and types for the clip-space triangle cull block.
package ctc_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned CROSS_SHIFT = 2 * FRAC_BITS - 12;
  // Width of a shifted cross product (arithmetic shift of a 64-bit value)
  localparam int unsigned CROSS_W     = 64 - CROSS_SHIFT;

  // Cycles from accepted start to the result strobe being sampled
  localparam int unsigned LATENCY     = 5;

  // Configuration register indexes
  localparam logic [1:0] REG_CULL_EN    = 2'd0;
  localparam logic [1:0] REG_CULL_MODE  = 2'd1;
  localparam logic [1:0] REG_FRONT_WIND = 2'd2;
  localparam logic [1:0] REG_TWO_SIDED  = 2'd3;

  // Cull face modes
  localparam logic [1:0] MODE_BACK  = 2'd0;
  localparam logic [1:0] MODE_FRONT = 2'd1;
  localparam logic [1:0] MODE_BOTH  = 2'd2;

  // Orientation codes (two's complement sign)
  localparam logic [1:0] ORIENT_ZERO = 2'b00;
  localparam logic [1:0] ORIENT_POS  = 2'b01;
  localparam logic [1:0] ORIENT_NEG  = 2'b11;

  // Operands of one weighted cross-product term: w * ((xa*yb - xb*ya) >>> S)
  typedef struct packed {
    logic signed [31:0] xa;
    logic signed [31:0] yb;
    logic signed [31:0] xb;
    logic signed [31:0] ya;
    logic signed [31:0] w;
  } lane_in_t;

endpackage

/* sv/ctc_lane.sv */
// Four-stage pipeline for one weighted 2x2 cross-product term, modulo 2^64.
module ctc_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ctc_pkg::lane_in_t  op_i,
  output logic               valid_o,
  output logic [63:0]        term_o
);

  // Stage A: the two 32x32 products
  logic                       a_vld_q;
  logic signed [63:0]         pa_q, pb_q, pa_d, pb_d;
  logic signed [31:0]         wa_q;
  // Stage B: shifted cross product
  logic                       b_vld_q;
  logic signed [63:0]         diff;
  logic signed [ctc_pkg::CROSS_W-1:0] c_q, c_d;
  logic signed [31:0]         wb_q;
  // Stage C: partial products of w * c
  logic                       c_vld_q;
  logic signed [63:0]         c64;
  logic signed [64:0]         lo_full;
  logic        [31:0]         hi_full;
  logic        [63:0]         lo_q;
  logic        [31:0]         hi_q;
  // Stage D: term
  logic                       d_vld_q;
  logic        [63:0]         term_q, term_d;

  assign pa_d = op_i.xa * op_i.yb;
  assign pb_d = op_i.xb * op_i.ya;

  assign diff = pa_q - pb_q;
  assign c_d  = ctc_pkg::CROSS_W'(diff >>> ctc_pkg::CROSS_SHIFT);

  assign c64     = 64'(c_q);
  assign lo_full = $signed({wb_q[31], wb_q}) * $signed({1'b0, c64[31:0]});
  // only the low half of the upper partial product survives the wrap
  assign hi_full = $unsigned(wb_q) * $unsigned(c64[63:32]);

  assign term_d = lo_q + {hi_q, 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      wa_q <= op_i.w;
    end
    if (a_vld_q) begin
      c_q  <= c_d;
      wb_q <= wa_q;
    end
    if (b_vld_q) begin
      lo_q <= lo_full[63:0];
      hi_q <= hi_full;
    end
    if (c_vld_q) begin
      term_q <= term_d;
    end
  end

  assign valid_o = d_vld_q;
  assign term_o  = term_q;

endmodule

/* sv/clip_space_triangle_cull_top.sv */
// Top level of the clip-space triangle cull block: lanes, final sum and cull decision.
//
// Usage:
//   Input: drive the nine vertex fields (v0..v2 x, y, w; signed fixed point)
//   and raise start_i. The triangle transfers at the rising edge where
//   start_i is high and busy_o is low. busy_o is always low: the datapath is
//   fully pipelined and takes a new triangle every cycle.
//   Output: done_o is high for exactly one cycle with draw_o, orientation_o
//   and use_back_color_o. The transfer completes at the edge ending that
//   cycle; results appear in input order.
//   Stages: 32x32 products, cross difference and shift, split w*c partial
//   products, term assembly, three-term sum plus decision.
//   Throughput: one triangle per clock, set by the pipelined multipliers.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at the
//   clock edge; write only while no triangle is in flight.
//   Reset: rst_ni clears all valid bits and configuration registers (culling
//   off, back-face mode, default winding, one-sided lighting).
//   The receiver cannot stall; results are never held back.
`include "assert_macros.svh"

module clip_space_triangle_cull_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [1:0]         cfg_wdata_i,
  // triangle input
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] v0_x_i,
  input  logic signed [31:0] v0_y_i,
  input  logic signed [31:0] v0_w_i,
  input  logic signed [31:0] v1_x_i,
  input  logic signed [31:0] v1_y_i,
  input  logic signed [31:0] v1_w_i,
  input  logic signed [31:0] v2_x_i,
  input  logic signed [31:0] v2_y_i,
  input  logic signed [31:0] v2_w_i,
  // result
  output logic               done_o,
  output logic               draw_o,
  output logic signed [1:0]  orientation_o,
  output logic               use_back_color_o
);

  logic              cull_en_q, front_wind_q, two_sided_q;
  logic [1:0]        cull_mode_q;

  logic              in_xfer;
  ctc_pkg::lane_in_t op0, op1, op2;
  logic              vld0, vld1, vld2;
  logic [63:0]       term0, term1, term2;

  logic [63:0]       sum;
  logic              neg, pos, culled;
  logic              done_q;
  logic              draw_q, draw_d, back_q, back_d;
  logic [1:0]        orient_q, orient_d;

  // no stall source anywhere in the pipeline
  assign busy_o  = 1'b0;
  assign in_xfer = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_en_q    <= 1'b0;
      cull_mode_q  <= ctc_pkg::MODE_BACK;
      front_wind_q <= 1'b0;
      two_sided_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ctc_pkg::REG_CULL_EN:    cull_en_q    <= cfg_wdata_i[0];
        ctc_pkg::REG_CULL_MODE:  cull_mode_q  <= cfg_wdata_i;
        ctc_pkg::REG_FRONT_WIND: front_wind_q <= cfg_wdata_i[0];
        ctc_pkg::REG_TWO_SIDED:  two_sided_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Three cofactor lanes: w0*c0, w1*c1, w2*c2
  //   c0 = x1*y2 - x2*y1, c1 = x0*y2 - x2*y0, c2 = x0*y1 - x1*y0
  // ---------------------------------------------------------------------------
  assign op0 = '{xa: v1_x_i, yb: v2_y_i, xb: v2_x_i, ya: v1_y_i, w: v0_w_i};
  assign op1 = '{xa: v0_x_i, yb: v2_y_i, xb: v2_x_i, ya: v0_y_i, w: v1_w_i};
  assign op2 = '{xa: v0_x_i, yb: v1_y_i, xb: v1_x_i, ya: v0_y_i, w: v2_w_i};

  ctc_lane u_lane0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .op_i    (op0),
    .valid_o (vld0),
    .term_o  (term0)
  );

  ctc_lane u_lane1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .op_i    (op1),
    .valid_o (vld1),
    .term_o  (term1)
  );

  ctc_lane u_lane2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .op_i    (op2),
    .valid_o (vld2),
    .term_o  (term2)
  );

  // ---------------------------------------------------------------------------
  // Final stage: determinant sign and cull decision
  // ---------------------------------------------------------------------------
  assign sum = term0 - term1 + term2;
  // sign of sum >>> FRAC_BITS: negative iff sum negative, zero iff upper bits clear
  assign neg = sum[63];
  assign pos = !neg && (sum[63:ctc_pkg::FRAC_BITS] != '0);

  always_comb begin
    case (cull_mode_q)
      ctc_pkg::MODE_BOTH: culled = 1'b1;
      ctc_pkg::MODE_BACK: culled = neg ^ front_wind_q;
      default:            culled = pos ^ front_wind_q;  // front, and the unused code
    endcase
  end

  assign orient_d = neg ? ctc_pkg::ORIENT_NEG : (pos ? ctc_pkg::ORIENT_POS : ctc_pkg::ORIENT_ZERO);
  assign draw_d   = !(cull_en_q && culled);
  assign back_d   = draw_d && two_sided_q && culled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld0) begin
      draw_q   <= draw_d;
      orient_q <= orient_d;
      back_q   <= back_d;
    end
  end

  assign done_o           = done_q;
  assign draw_o           = draw_q;
  assign orientation_o    = orient_q;
  assign use_back_color_o = back_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CTC_ASSERT_IMP(a_fixed_latency, in_xfer, ##(ctc_pkg::LATENCY) done_o)
  `CTC_ASSERT(a_lanes_in_step, (vld0 == vld1) && (vld1 == vld2))
  `CTC_ASSERT_IMP(a_back_only_drawn, done_o && use_back_color_o, draw_o && two_sided_q)
  `CTC_ASSERT_IMP(a_discard_needs_cull, done_o && !draw_o, cull_en_q)
  `CTC_ASSERT_IMP(a_orient_code, done_o, orientation_o != 2'sb10)

endmodule

/* test/clip_space_triangle_cull_top_tb.sv */
// Self-checking testbench for the clip-space triangle cull block.
`timescale 1ns / 1ps

module clip_space_triangle_cull_top_tb;

  // Generous bound: about 800 triangles, sent in bursts with sender gaps
  // between them, plus phase turnarounds, fit well inside it.
  localparam int CYCLE_LIMIT = 200000;

  // One triangle as it sits on the input ports
  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_w;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_w;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_w;
  } triangle_t;

  // Cull verdict for one triangle
  typedef struct packed {
    logic       draw;
    logic [1:0] orient;
    logic       back;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = ctc_pkg::REG_CULL_EN;
  logic [1:0] cfg_wdata_i = 2'b00;

  logic      start_i = 1'b0;
  logic      busy_o;
  triangle_t cur_tri = '0;

  logic              done_o;
  logic              draw_o;
  logic signed [1:0] orientation_o;
  logic              use_back_color_o;

  // Shadow copy of the configuration registers, used by the predictor
  logic       cull_en_q = 1'b0;
  logic [1:0] face_mode_q = ctc_pkg::MODE_BACK;
  logic       winding_q = 1'b0;
  logic       two_sided_q = 1'b0;

  triangle_t pending_tris[$];
  verdict_t  expected_verdicts[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;

  always #1 clk_i = ~clk_i;

  clip_space_triangle_cull_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .v0_x_i           (cur_tri.v0_x),
    .v0_y_i           (cur_tri.v0_y),
    .v0_w_i           (cur_tri.v0_w),
    .v1_x_i           (cur_tri.v1_x),
    .v1_y_i           (cur_tri.v1_y),
    .v1_w_i           (cur_tri.v1_w),
    .v2_x_i           (cur_tri.v2_x),
    .v2_y_i           (cur_tri.v2_y),
    .v2_w_i           (cur_tri.v2_w),
    .done_o           (done_o),
    .draw_o           (draw_o),
    .orientation_o    (orientation_o),
    .use_back_color_o (use_back_color_o)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // (xa*yb - xb*ya) >>> CROSS_SHIFT, everything 64-bit and wrapping
  function automatic logic signed [63:0] cross_term(logic signed [31:0] xa,
                                                    logic signed [31:0] yb,
                                                    logic signed [31:0] xb,
                                                    logic signed [31:0] ya);
    logic signed [63:0] a, b, c, d;
    a = xa;
    b = yb;
    c = xb;
    d = ya;
    return (a * b - c * d) >>> ctc_pkg::CROSS_SHIFT;
  endfunction

  function automatic verdict_t predict_cull(triangle_t t);
    logic signed [63:0] c0, c1, c2, w0, w1, w2, det;
    logic neg, pos, culled;
    verdict_t v;
    c0 = cross_term(t.v1_x, t.v2_y, t.v2_x, t.v1_y);
    c1 = cross_term(t.v0_x, t.v2_y, t.v2_x, t.v0_y);
    c2 = cross_term(t.v0_x, t.v1_y, t.v1_x, t.v0_y);
    w0 = t.v0_w;
    w1 = t.v1_w;
    w2 = t.v2_w;
    det = (w0 * c0 - w1 * c1 + w2 * c2) >>> ctc_pkg::FRAC_BITS;
    neg = det[63];
    pos = !neg && (det != 64'sd0);
    v.orient = neg ? ctc_pkg::ORIENT_NEG : (pos ? ctc_pkg::ORIENT_POS : ctc_pkg::ORIENT_ZERO);
    // Mode 3 is unused and falls through to the front-face test
    if (face_mode_q == ctc_pkg::MODE_BOTH) begin
      culled = 1'b1;
    end else if (face_mode_q == ctc_pkg::MODE_BACK) begin
      culled = neg ^ winding_q;
    end else begin
      culled = pos ^ winding_q;
    end
    v.draw = !(cull_en_q && culled);
    v.back = v.draw && two_sided_q && culled;
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic triangle_t make_tri(int x0, int y0, int w0, int x1, int y1, int w1,
                                         int x2, int y2, int w2);
    triangle_t t;
    t.v0_x = x0; t.v0_y = y0; t.v0_w = w0;
    t.v1_x = x1; t.v1_y = y1; t.v1_w = w1;
    t.v2_x = x2; t.v2_y = y2; t.v2_w = w2;
    return t;
  endfunction

  // Coordinate of a given flavor: 0 screen-like, 1 full range, 2 corner values,
  // 3 tiny (cross products shift down to small values), 4 positive w around 1.0
  function automatic logic signed [31:0] rand_coord(int flavor);
    logic signed [31:0] r;
    case (flavor)
      0: r = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      1: r = $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: r = 32'h7FFF_FFFF;
          1: r = 32'h8000_0000;
          2: r = 32'h0000_0000;
          3: r = 32'hFFFF_FFFF;
          4: r = 32'h0000_0001;
          default: r = 32'h0001_0000;
        endcase
      end
      3: r = $signed($urandom_range(0, 8192)) - 32'sd4096;
      default: r = $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
    return r;
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int kind, cf, wf;
    kind = $urandom_range(0, 9);
    // Mostly well-formed geometry; the rest is full-range, corner or tiny noise
    cf = (kind < 6) ? 0 : (kind == 6) ? 1 : (kind == 7) ? 2 : (kind == 8) ? 3 : 0;
    wf = (kind < 6 || kind == 9) ? 4 : cf;
    // Occasional negative w on screen-like triangles (behind the eye)
    if (kind < 6 && $urandom_range(0, 7) == 0) wf = 1;
    t.v0_x = rand_coord(cf); t.v0_y = rand_coord(cf); t.v0_w = rand_coord(wf);
    t.v1_x = rand_coord(cf); t.v1_y = rand_coord(cf); t.v1_w = rand_coord(wf);
    t.v2_x = rand_coord(cf); t.v2_y = rand_coord(cf); t.v2_w = rand_coord(wf);
    // Degenerate: v2 repeats the x and y of v0 or v1
    if (kind == 9) begin
      if ($urandom_range(0, 1)) begin
        t.v2_x = t.v0_x;
        t.v2_y = t.v0_y;
      end else begin
        t.v2_x = t.v1_x;
        t.v2_y = t.v1_y;
      end
    end
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Config write; shadow copy tracks the register, including masking
  task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      ctc_pkg::REG_CULL_EN:    cull_en_q = data[0];
      ctc_pkg::REG_CULL_MODE:  face_mode_q = data;
      ctc_pkg::REG_FRONT_WIND: winding_q = data[0];
      ctc_pkg::REG_TWO_SIDED:  two_sided_q = data[0];
      default: ;
    endcase
  endtask

  // Sampled at the falling edge so the queue sizes and start_i are settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (!(pending_tris.size() == 0 && !start_i && expected_verdicts.size() == 0))
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Driver: one transfer per edge with start_i high and busy_o low.
  // Bursts of random length separated by random gaps; gap 0 gives runs
  // of back-to-back triangles.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_verdicts.push_back(predict_cull(cur_tri));
      end
      if (start_i && busy_o) begin
        // hold the current triangle until it is taken
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left--;
      end else if (pending_tris.size() > 0) begin
        cur_tri <= pending_tris.pop_front();
        start_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobe is checked against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && done_o) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result strobe with no triangle outstanding");
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (draw_o !== exp_v.draw)
          report_mismatch($sformatf("draw: got %b expected %b", draw_o, exp_v.draw));
        if (orientation_o !== exp_v.orient)
          report_mismatch($sformatf("orientation: got %b expected %b",
                                    orientation_o, exp_v.orient));
        if (use_back_color_o !== exp_v.back)
          report_mismatch($sformatf("use_back_color: got %b expected %b",
                                    use_back_color_o, exp_v.back));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: directed triangles at reset config, then one random phase
  // per configuration combination (all 32, mode 3 included). Registers
  // change only once the pipe has drained.
  // ---------------------------------------------------------------------
  initial begin
    logic [4:0] setting;
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed set: fields at their extremes, both windings, degenerate,
    // wrapping products, values whose cross products shift to nothing
    @(negedge clk_i);
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 65536, 65536, 0, 65536, 0, 65536, 65536));
    pending_tris.push_back(make_tri(0, 0, 65536, 0, 65536, 65536, 65536, 0, 65536));
    pending_tris.push_back(make_tri(0, 0, 65536, 65536, 65536, 65536,
                                    131072, 131072, 65536));
    pending_tris.push_back(make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_tris.push_back(make_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_tris.push_back(make_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_tris.push_back(make_tri(0, 0, -65536, 65536, 0, -65536, 0, 65536, -65536));
    pending_tris.push_back(make_tri(32'h4000_0000, 32'hC000_0000, 32'h4000_0000,
                                    32'hC000_0000, 32'h4000_0000, 32'h7FFF_0000,
                                    32'h3FFF_FFFF, 32'h4000_0001, 32'h8000_0001));
    pending_tris.push_back(make_tri(1, 2, 65536, 3, 1, 65536, 2, 3, 65536));
    pending_tris.push_back(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_tris.push_back(make_tri(-65536, 32768, 65536, 98304, -16384, -131072,
                                    12345, 54321, 262144));
    pending_tris.push_back(make_tri(32'h0000_FFFF, 32'hFFFF_0000, 32'h5555_5555,
                                    32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                                    32'h3333_3333, 32'hCCCC_CCCC, 32'h0001_0000));

    for (int s = 0; s < 32; s++) begin
      setting = s;
      wait_drained();
      // Unused upper data bit goes along on the 1-bit registers; it must be dropped
      write_reg(ctc_pkg::REG_CULL_EN, {1'($urandom_range(0, 1)), setting[0]});
      write_reg(ctc_pkg::REG_CULL_MODE, setting[2:1]);
      write_reg(ctc_pkg::REG_FRONT_WIND, {1'($urandom_range(0, 1)), setting[3]});
      write_reg(ctc_pkg::REG_TWO_SIDED, {1'($urandom_range(0, 1)), setting[4]});
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
      n = $urandom_range(20, 27);
      for (int i = 0; i < n; i++) pending_tris.push_back(random_triangle());
    end

    wait_drained();
    // Let any stray strobe surface before the verdict
    repeat (ctc_pkg::LATENCY + 4) @(posedge clk_i);
    if (expected_verdicts.size() != 0)
      report_mismatch("triangles left without a result");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
